// ----- sv/qalu_pkg.sv -----
// Shared types and constants for the quaternion ALU.
package qalu_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  // Per-stage control handed to each lane
  typedef struct packed {
    logic    en;
    action_e action;
  } ctl_t;

  // Hamilton product: lane L, term t is p[t] * y[t ^ L]; set bit = subtract
  localparam logic [3:0] NEG_MASK [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// ----- sv/quaternion_alu_top.sv -----
// Quaternion ALU top level: input stage, norm, four lanes and result merge.
//
// Computes p+q, p-q, the Hamilton product p*q or the right quotient
// p*conj(q)/|q|^2 on signed fixed-point components (FRACTION_BITS fraction
// bits), rounding to nearest with ties away from zero and saturating each
// component. One beat is taken every clock while the output is not
// stalled. The pipeline depth is set by the divider, which resolves one
// quotient bit per pipeline stage in each of the four lanes; every action
// runs through the same depth so results stay in order. Four lanes, one
// per component, form the product terms; shared stages form |q|^2, and
// the merge stage ORs the lane overflow flags and forces a zero result
// with divide_by_zero when a division sees a zero norm. When the output
// beat is stalled the whole pipeline holds and in_stall_o is raised.
module quaternion_alu_top
  import qalu_pkg::*;
#(
  parameter int FRACTION_BITS   = 8,
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_real_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_i_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_j_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_k_i,
  input  logic signed [COMPONENT_WIDTH-1:0] q_real_i,
  input  logic signed [COMPONENT_WIDTH-1:0] q_i_i,
  input  logic signed [COMPONENT_WIDTH-1:0] q_j_i,
  input  logic signed [COMPONENT_WIDTH-1:0] q_k_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COMPONENT_WIDTH-1:0] r_real_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_i_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_j_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_k_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int DW = 2 * W + 1;

  // Global advance: hold everything while the output beat waits
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Input stage
  logic              vld0_q;
  action_e           act0_q;
  logic signed [W-1:0] p0_q [4];
  logic signed [W-1:0] q0_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act0_q  <= action_e'(action_i);
      p0_q[0] <= p_real_i;
      p0_q[1] <= p_i_i;
      p0_q[2] <= p_j_i;
      p0_q[3] <= p_k_i;
      q0_q[0] <= q_real_i;
      q0_q[1] <= q_i_i;
      q0_q[2] <= q_j_i;
      q0_q[3] <= q_k_i;
    end
  end

  // Norm of q: squares, then sum; lines up with the lane term sums
  logic signed [2*W-1:0] sq_q [4];
  logic [DW-1:0]         n_q;
  action_e               act1_q, act2_q;
  logic                  vld1_q, vld2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 4; t++) sq_q[t] <= (2*W)'(q0_q[t]) * (2*W)'(q0_q[t]);
      act1_q <= act0_q;
      n_q    <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]) + DW'(sq_q[3]);
      act2_q <= act1_q;
    end
  end

  // Sideband delay matching lane stage 3 plus the divider
  logic dz2;
  logic vld_dl_q [W+1];
  logic dz_dl_q  [W+1];

  assign dz2 = (act2_q == ACT_DIV) && (n_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= W; s++) vld_dl_q[s] <= 1'b0;
    end else if (en) begin
      vld_dl_q[0] <= vld2_q;
      for (int s = 1; s <= W; s++) vld_dl_q[s] <= vld_dl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dz_dl_q[0] <= dz2;
      for (int s = 1; s <= W; s++) dz_dl_q[s] <= dz_dl_q[s-1];
    end
  end

  // Lanes
  ctl_t         ctl;
  logic [W-1:0] lane_res [4];
  logic [3:0]   lane_ovf;

  assign ctl = '{en: en, action: act0_q};

  for (genvar l = 0; l < 4; l++) begin : g_lane
    qalu_lane #(.W(W), .F(FRACTION_BITS), .LANE(l)) u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .p_i   (p0_q),
      .q_i   (q0_q),
      .n_i   (n_q),
      .res_o (lane_res[l]),
      .ovf_o (lane_ovf[l])
    );
  end

  // Merge and output register
  logic dz_end;
  assign dz_end = dz_dl_q[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_dl_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_real_o         <= dz_end ? '0 : lane_res[0];
      r_i_o            <= dz_end ? '0 : lane_res[1];
      r_j_o            <= dz_end ? '0 : lane_res[2];
      r_k_o            <= dz_end ? '0 : lane_res[3];
      overflow_o       <= !dz_end && (|lane_ovf);
      divide_by_zero_o <= dz_end;
    end
  end

endmodule

// ----- sv/qalu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module qalu_div
  import qalu_pkg::*;
#(
  parameter int QW   = 16,
  parameter int NW   = 45,
  parameter int DENW = 34
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   quot_o
);

  localparam int CW = NW + QW;

  logic [NW-1:0]   rem_q  [QW];
  logic [DENW-1:0] den_q  [QW];
  logic [QW-1:0]   quot_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0]   rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   quot_in;
    logic [CW-1:0]   shifted;
    logic            take;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    assign shifted = CW'(den_in) << (QW - 1 - s);
    assign take    = CW'(rem_in) >= shifted;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? NW'(CW'(rem_in) - shifted) : rem_in;
        den_q[s]  <= den_in;
        quot_q[s] <= quot_in | (take ? (QW'(1) << (QW - 1 - s)) : '0);
      end
    end
  end

  assign quot_o = quot_q[QW-1];

endmodule

// ----- sv/qalu_lane.sv -----
// One result component: product terms, rounding, division and saturation.
module qalu_lane
  import qalu_pkg::*;
#(
  parameter int W    = 16,
  parameter int F    = 8,
  parameter int LANE = 0
) (
  input  logic                clk_i,
  input  ctl_t                ctl_i,
  input  logic signed [W-1:0] p_i [4],
  input  logic signed [W-1:0] q_i [4],
  input  logic [2*W:0]        n_i,
  output logic [W-1:0]        res_o,
  output logic                ovf_o
);

  localparam int PW   = 2 * W + 1;
  localparam int WW   = 2 * W + 3;
  localparam int DW   = 2 * W + 1;
  localparam int MW   = WW + F + 2;
  localparam int CW   = MW + W;
  localparam int HALF = (2 ** F) / 2;
  localparam logic [1:0]    LN      = 2'(LANE);
  localparam logic [MW-1:0] NEG_MAX = MW'(1) << (W - 1);
  localparam logic [MW-1:0] POS_MAX = NEG_MAX - MW'(1);

  // {ovf, value}
  function automatic logic [W:0] sat_fn(input logic [MW-1:0] mag, input logic neg);
    logic [W:0] r;
    if (!neg && mag > POS_MAX) begin
      r = {1'b1, 1'b0, {(W-1){1'b1}}};
    end else if (neg && mag > NEG_MAX) begin
      r = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, (neg ? W'(-mag[W-1:0]) : mag[W-1:0])};
    end
    return r;
  endfunction

  // stage 1: products and add/sub
  logic signed [W:0]    y [4];
  logic signed [PW-1:0] prod_q [4];
  logic signed [W:0]    as1_q;
  action_e              act1_q;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      if (ctl_i.action == ACT_DIV && t != 0) y[t] = -{q_i[t][W-1], q_i[t]};
      else                                   y[t] = {q_i[t][W-1], q_i[t]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int t = 0; t < 4; t++) prod_q[t] <= PW'(p_i[t]) * PW'(y[2'(t) ^ LN]);
      if (ctl_i.action == ACT_SUB)
        as1_q <= {p_i[LANE][W-1], p_i[LANE]} - {q_i[LANE][W-1], q_i[LANE]};
      else
        as1_q <= {p_i[LANE][W-1], p_i[LANE]} + {q_i[LANE][W-1], q_i[LANE]};
      act1_q <= ctl_i.action;
    end
  end

  // stage 2: term sum
  logic signed [WW-1:0] w_d, w_q;
  logic signed [W:0]    as2_q;
  action_e              act2_q;

  always_comb begin
    w_d = '0;
    for (int t = 0; t < 4; t++) begin
      if (NEG_MASK[LANE][t]) w_d = w_d - WW'(prod_q[t]);
      else                   w_d = w_d + WW'(prod_q[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      w_q    <= w_d;
      as2_q  <= as1_q;
      act2_q <= act1_q;
    end
  end

  // stage 3: round, add/sub and product saturation, divider setup
  logic          neg, as_neg, pre;
  logic [WW-1:0] mag;
  logic [W:0]    as_mag;
  logic [MW-1:0] rnd, num;
  logic [DW:0]   den;
  logic [W:0]    oth;

  always_comb begin
    neg    = w_q[WW-1];
    mag    = neg ? WW'(-w_q) : WW'(w_q);
    rnd    = (MW'(mag) + MW'(HALF)) >> F;
    num    = (MW'(mag) << (F + 1)) + MW'(n_i);
    den    = {n_i, 1'b0};
    pre    = CW'(num) >= (CW'(den) << W);
    as_neg = as2_q[W];
    as_mag = as_neg ? (W+1)'(-as2_q) : (W+1)'(as2_q);
    unique case (act2_q)
      ACT_ADD, ACT_SUB: oth = sat_fn(MW'(as_mag), as_neg);
      ACT_MUL:          oth = sat_fn(rnd, neg);
      default:          oth = '0;
    endcase
  end

  logic [MW-1:0] num_q;
  logic [DW:0]   den_q;
  logic [W:0]    dl_oth [W+1];
  logic [2:0]    dl_flg [W+1];  // {is_div, neg, pre}

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      num_q     <= num;
      den_q     <= den;
      dl_oth[0] <= oth;
      dl_flg[0] <= {act2_q == ACT_DIV, neg, pre};
      for (int s = 1; s <= W; s++) begin
        dl_oth[s] <= dl_oth[s-1];
        dl_flg[s] <= dl_flg[s-1];
      end
    end
  end

  logic [W-1:0] quot;

  qalu_div #(.QW(W), .NW(MW), .DENW(DW + 1)) u_div (
    .clk_i  (clk_i),
    .en_i   (ctl_i.en),
    .num_i  (num_q),
    .den_i  (den_q),
    .quot_o (quot)
  );

  logic [W:0] fin;

  always_comb begin
    if (!dl_flg[W][2]) begin
      fin = dl_oth[W];
    end else if (dl_flg[W][0]) begin
      fin = dl_flg[W][1] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
    end else begin
      fin = sat_fn(MW'(quot), dl_flg[W][1]);
    end
  end

  assign ovf_o = fin[W];
  assign res_o = fin[W-1:0];

endmodule

// ----- sv/qalu_checker.sv -----
// Port-level checks for the quaternion ALU, bound to the top level.
module qalu_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [COMPONENT_WIDTH-1:0] r_real_o,
  input logic [COMPONENT_WIDTH-1:0] r_i_o,
  input logic [COMPONENT_WIDTH-1:0] r_j_o,
  input logic [COMPONENT_WIDTH-1:0] r_k_o,
  input logic                       overflow_o,
  input logic                       divide_by_zero_o
);

  // Zero-norm divide: zero result, no overflow
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> !overflow_o && r_real_o == '0 &&
      r_i_o == '0 && r_j_o == '0 && r_k_o == '0)
    else $error("divide_by_zero beat with nonzero result or overflow");

  // Input only stalls behind a stalled output beat
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Stalled output beat holds its valid, real and k components and overflow flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r_real_o) &&
      $stable(r_k_o) && $stable(overflow_o))
    else $error("stalled output beat changed");

endmodule

bind quaternion_alu_top qalu_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_qalu_checker (.*);
